// ----- sv/jsu_pkg.sv -----
// Shared types, character constants and decode helpers of the JSON string unescaper.
package jsu_pkg;

	typedef enum logic [1:0] {
		ST_DATA  = 2'd0,
		ST_END   = 2'd1,
		ST_ERROR = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ERR_NONE       = 3'd0,
		ERR_NO_QUOTE   = 3'd1,
		ERR_CONTROL    = 3'd2,
		ERR_BAD_ESCAPE = 3'd3,
		ERR_BAD_LEAD   = 3'd4,
		ERR_RAW_C0_80  = 3'd5
	} err_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       start_of_string;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		status_t    status;
		err_t       error_code;
		logic       last_of_run;
	} out_item_t;

	// All results caused by one input item; only the last slot may carry end or error.
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [1:0]      last_idx;
		status_t         fin_stat;
		err_t            fin_err;
	} run_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_SLASH  = 8'h2f;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UF     = 8'h46;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_LF     = 8'h66;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6e;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_U      = 8'h75;

	localparam logic [7:0] CTRL_MAX  = 8'h1f;
	localparam logic [7:0] RAW_C0    = 8'hc0;
	localparam logic [7:0] CONT_80   = 8'h80;
	localparam logic [5:0] SURR_HIGH = 6'b110110;
	localparam logic [20:0] SUPP_BASE = 21'h10000;

	// UTF-8 sequence length from the lead byte; zero for an invalid lead.
	function automatic logic [2:0] lead_len(input logic [7:0] b);
		if (!b[7])
			return 3'd1;
		else if (b[7:5] == 3'b110)
			return 3'd2;
		else if (b[7:4] == 4'b1110)
			return 3'd3;
		else if (b[7:3] == 5'b11110)
			return 3'd4;
		else
			return 3'd0;
	endfunction

	// Bit 4 flags a hex digit, bits 3:0 hold its value.
	function automatic logic [4:0] hexval(input logic [7:0] b);
		if (b >= CH_0 && b <= CH_9)
			return {1'b1, b[3:0]};
		else if ((b >= CH_UA && b <= CH_UF) || (b >= CH_LA && b <= CH_LF))
			return {1'b1, 4'(b[3:0] + 4'd9)};
		else
			return 5'd0;
	endfunction

	// Bit 8 flags a known single-character escape, bits 7:0 hold the decoded byte.
	function automatic logic [8:0] simple_esc(input logic [7:0] b);
		case (b)
			CH_BSLASH: return {1'b1, CH_BSLASH};
			CH_QUOTE:  return {1'b1, CH_QUOTE};
			CH_SLASH:  return {1'b1, CH_SLASH};
			CH_B:      return {1'b1, 8'h08};
			CH_F:      return {1'b1, 8'h0c};
			CH_N:      return {1'b1, 8'h0a};
			CH_R:      return {1'b1, 8'h0d};
			CH_T:      return {1'b1, 8'h09};
			default:   return 9'd0;
		endcase
	endfunction

endpackage

// ----- sv/jsu_front.sv -----
// Front end: accepts input items, runs the string decoder and pushes one run per item that causes results.
module jsu_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  jsu_pkg::in_item_t  in_item,
	input  jsu_pkg::q_stat_t   q_stat,
	output logic               push,
	output jsu_pkg::run_t      push_run
);

	typedef enum logic [6:0] {
		PH_IDLE     = 7'b0000001,
		PH_BODY     = 7'b0000010,
		PH_ESC      = 7'b0000100,
		PH_HEX1     = 7'b0001000,
		PH_HIGH     = 7'b0010000,
		PH_HIGH_ESC = 7'b0100000,
		PH_HEX2     = 7'b1000000
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [15:0] acc_q, acc_d;
	logic [9:0]  held_q, held_d;
	logic [1:0]  dig_q, dig_d;
	logic [1:0]  cont_q, cont_d;
	logic        esc_q, esc_d;
	logic        prev_q, prev_d;

	logic [7:0]  c;
	logic [4:0]  hexd;
	logic [15:0] acc_new;
	logic [8:0]  sesc;
	logic [2:0]  ll;
	logic [20:0] u4;
	logic [7:0]  hh0, hh1, hh2;

	logic [3:0][7:0] slot;
	logic [2:0]      cnt;
	logic            do_fail, do_end, do_body, do_simple;
	jsu_pkg::err_t   fail_code;
	jsu_pkg::status_t fin_stat;
	jsu_pkg::err_t   fin_err;
	logic            accept;

	assign c       = in_item.in_byte;
	assign hexd    = jsu_pkg::hexval(c);
	assign acc_new = {acc_q[11:0], hexd[3:0]};
	assign sesc    = jsu_pkg::simple_esc(c);
	assign ll      = jsu_pkg::lead_len(c);
	assign u4      = {1'b0, held_q, 10'd0} + {11'd0, acc_new[9:0]} + jsu_pkg::SUPP_BASE;

	// Three-byte form of the held high surrogate.
	assign hh0 = 8'hed;
	assign hh1 = {4'b1010, held_q[9:6]};
	assign hh2 = {2'b10, held_q[5:0]};

	assign in_ready = !q_stat.full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		phase_d   = phase_q;
		acc_d     = acc_q;
		held_d    = held_q;
		dig_d     = dig_q;
		cont_d    = cont_q;
		esc_d     = esc_q;
		prev_d    = prev_q;
		slot      = '0;
		cnt       = 3'd0;
		do_fail   = 1'b0;
		do_end    = 1'b0;
		do_body   = 1'b0;
		do_simple = 1'b0;
		fail_code = jsu_pkg::ERR_NONE;
		fin_stat  = jsu_pkg::ST_DATA;
		fin_err   = jsu_pkg::ERR_NONE;

		if (in_item.start_of_string) begin
			acc_d  = '0;
			held_d = '0;
			dig_d  = '0;
			cont_d = '0;
			esc_d  = 1'b0;
			prev_d = 1'b0;
			if (c == jsu_pkg::CH_QUOTE) begin
				phase_d = PH_BODY;
			end else begin
				phase_d   = PH_IDLE;
				do_fail   = 1'b1;
				fail_code = jsu_pkg::ERR_NO_QUOTE;
			end
		end else begin
			case (phase_q)
				PH_BODY: begin
					if (cont_q != 2'd0) begin
						if (prev_q && c == jsu_pkg::CONT_80) begin
							do_fail   = 1'b1;
							fail_code = jsu_pkg::ERR_RAW_C0_80;
						end else begin
							prev_d = 1'b0;
							slot[cnt[1:0]] = c;
							cnt = cnt + 3'd1;
							cont_d = cont_q - 2'd1;
						end
					end else begin
						prev_d  = 1'b0;
						do_body = 1'b1;
					end
				end
				PH_ESC: begin
					if (c == jsu_pkg::CH_U) begin
						phase_d = PH_HEX1;
						acc_d   = '0;
						dig_d   = '0;
					end else begin
						do_simple = 1'b1;
					end
				end
				PH_HEX1, PH_HEX2: begin
					if (!hexd[4]) begin
						if (phase_q == PH_HEX2) begin
							slot[0] = hh0;
							slot[1] = hh1;
							slot[2] = hh2;
							cnt = 3'd3;
						end
						do_fail   = 1'b1;
						fail_code = jsu_pkg::ERR_BAD_ESCAPE;
					end else begin
						acc_d = acc_new;
						if (dig_q == 2'd3) begin
							dig_d   = 2'd0;
							phase_d = PH_BODY;
							if (phase_q == PH_HEX1) begin
								if (acc_new[15:7] == 9'd0) begin
									// U+0000 goes out in the two-byte form.
									if (acc_new == 16'd0) begin
										slot[0] = jsu_pkg::RAW_C0;
										slot[1] = jsu_pkg::CONT_80;
										cnt = 3'd2;
									end else begin
										slot[0] = acc_new[7:0];
										cnt = 3'd1;
									end
								end else if (acc_new[15:11] == 5'd0) begin
									slot[0] = {3'b110, acc_new[10:6]};
									slot[1] = {2'b10, acc_new[5:0]};
									cnt = 3'd2;
								end else if (acc_new[15:10] == jsu_pkg::SURR_HIGH) begin
									held_d  = acc_new[9:0];
									phase_d = PH_HIGH;
								end else begin
									slot[0] = {4'b1110, acc_new[15:12]};
									slot[1] = {2'b10, acc_new[11:6]};
									slot[2] = {2'b10, acc_new[5:0]};
									cnt = 3'd3;
								end
							end else begin
								slot[0] = {5'b11110, u4[20:18]};
								slot[1] = {2'b10, u4[17:12]};
								slot[2] = {2'b10, u4[11:6]};
								slot[3] = {2'b10, u4[5:0]};
								cnt = 3'd4;
							end
						end else begin
							dig_d = dig_q + 2'd1;
						end
					end
				end
				PH_HIGH: begin
					if (c == jsu_pkg::CH_BSLASH) begin
						phase_d = PH_HIGH_ESC;
					end else begin
						slot[0] = hh0;
						slot[1] = hh1;
						slot[2] = hh2;
						cnt = 3'd3;
						phase_d = PH_BODY;
						do_body = 1'b1;
					end
				end
				PH_HIGH_ESC: begin
					if (c == jsu_pkg::CH_U) begin
						phase_d = PH_HEX2;
						acc_d   = '0;
						dig_d   = '0;
					end else begin
						slot[0] = hh0;
						slot[1] = hh1;
						slot[2] = hh2;
						cnt = 3'd3;
						do_simple = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end

		if (do_simple) begin
			if (sesc[8]) begin
				slot[cnt[1:0]] = sesc[7:0];
				cnt = cnt + 3'd1;
				phase_d = PH_BODY;
			end else begin
				do_fail   = 1'b1;
				fail_code = jsu_pkg::ERR_BAD_ESCAPE;
			end
		end

		if (do_body) begin
			if (c <= jsu_pkg::CTRL_MAX) begin
				do_fail   = 1'b1;
				fail_code = jsu_pkg::ERR_CONTROL;
			end else if (c == jsu_pkg::CH_BSLASH) begin
				esc_d   = 1'b1;
				phase_d = PH_ESC;
			end else if (c == jsu_pkg::CH_QUOTE) begin
				do_end  = 1'b1;
				phase_d = PH_IDLE;
			end else if (ll == 3'd0) begin
				do_fail   = 1'b1;
				fail_code = jsu_pkg::ERR_BAD_LEAD;
			end else begin
				// A raw C0 before any escape arms the check on the next byte.
				if (c == jsu_pkg::RAW_C0 && !esc_d)
					prev_d = 1'b1;
				slot[cnt[1:0]] = c;
				cnt = cnt + 3'd1;
				cont_d  = 2'(ll - 3'd1);
				phase_d = PH_BODY;
			end
		end

		if (do_fail) begin
			slot[cnt[1:0]] = 8'd0;
			cnt = cnt + 3'd1;
			fin_stat = jsu_pkg::ST_ERROR;
			fin_err  = fail_code;
			phase_d  = PH_IDLE;
			cont_d   = 2'd0;
			prev_d   = 1'b0;
		end else if (do_end) begin
			slot[cnt[1:0]] = 8'd0;
			cnt = cnt + 3'd1;
			fin_stat = jsu_pkg::ST_END;
		end
	end

	assign push              = accept && (cnt != 3'd0);
	assign push_run.bytes    = slot;
	assign push_run.last_idx = 2'(cnt - 3'd1);
	assign push_run.fin_stat = fin_stat;
	assign push_run.fin_err  = fin_err;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			acc_q   <= '0;
			held_q  <= '0;
			dig_q   <= '0;
			cont_q  <= '0;
			esc_q   <= 1'b0;
			prev_q  <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			held_q  <= held_d;
			dig_q   <= dig_d;
			cont_q  <= cont_d;
			esc_q   <= esc_d;
			prev_q  <= prev_d;
		end
	end

endmodule

// ----- sv/jsu_queue.sv -----
// Run queue between the decoder front end and the output serializer.
module jsu_queue #(
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  jsu_pkg::run_t    push_run,
	input  logic             pop,
	output jsu_pkg::run_t    pop_run,
	output jsu_pkg::q_stat_t q_stat
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	jsu_pkg::run_t   mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push, do_pop;

	assign q_stat.full  = (count_q == CW'(DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign do_push      = push && !q_stat.full;
	assign do_pop       = pop && !q_stat.empty;
	assign pop_run      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_run;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// ----- sv/jsu_back.sv -----
// Back end: holds one run and hands out its results one item per cycle while out_ready is high.
module jsu_back (
	input  logic               clk,
	input  logic               arst_n,
	input  jsu_pkg::q_stat_t   q_stat,
	input  jsu_pkg::run_t      pop_run,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output jsu_pkg::out_item_t out_item
);

	jsu_pkg::run_t cur_q;
	logic          cur_valid_q;
	logic [1:0]    idx_q;
	logic          is_last, take;

	assign is_last   = (idx_q == cur_q.last_idx);
	assign out_valid = cur_valid_q;
	assign take      = out_valid && out_ready;
	assign pop       = !q_stat.empty && (!cur_valid_q || (take && is_last));

	assign out_item.out_byte    = cur_q.bytes[idx_q];
	assign out_item.status      = is_last ? cur_q.fin_stat : jsu_pkg::ST_DATA;
	assign out_item.error_code  = is_last ? cur_q.fin_err : jsu_pkg::ERR_NONE;
	assign out_item.last_of_run = is_last;

	always_ff @(posedge clk) begin
		if (pop)
			cur_q <= pop_run;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (pop) begin
			cur_valid_q <= 1'b1;
			idx_q       <= '0;
		end else if (take) begin
			if (is_last)
				cur_valid_q <= 1'b0;
			else
				idx_q <= idx_q + 2'd1;
		end
	end

endmodule

// ----- sv/json_string_unescape_core.sv -----
// Top level of the streaming JSON string unescaper: front end, run queue and serializer.
//
// Input channel (in_valid / in_ready / in_item): one byte of JSON text per item, with
// start_of_string marking the byte that must be the opening quote. Output channel
// (out_valid / out_ready / out_item): decoded UTF-8 bytes, then an end or error status
// item; last_of_run marks the final result caused by one input item.
//
// The front end decodes an item in the cycle it is accepted and writes all of its
// results (one to four) into the run queue as one entry; an item with no result writes
// nothing. The serializer loads an entry when its output stage is free and presents one
// result per cycle while out_ready is high; results pass through the queue memory and
// the output register before they become visible. Input items are taken one per cycle
// while the queue has room; the sustained input rate therefore follows the output rate,
// one result per cycle, and an item that causes no result takes no queue entry.
//
// When the receiver stalls, the current result holds and the queue fills; once it holds
// QUEUE_DEPTH runs, in_ready drops until the serializer frees an entry.
// Reset clears the decoder to the state that waits for an opening quote and empties
// the queue and the output stage.
module json_string_unescape_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  jsu_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output jsu_pkg::out_item_t out_item
);

	jsu_pkg::q_stat_t q_stat;
	jsu_pkg::run_t    push_run, pop_run;
	logic             push, pop;

	// Decoder: accepts items and produces one run of results per item that causes any.
	jsu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.q_stat   (q_stat),
		.push     (push),
		.push_run (push_run)
	);

	// Queue that lets the decoder run ahead of a stalled receiver.
	jsu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_run (push_run),
		.pop      (pop),
		.pop_run  (pop_run),
		.q_stat   (q_stat)
	);

	// Serializer: one result item per cycle from the head run while the receiver is ready.
	jsu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.pop_run   (pop_run),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	// An end or error status always closes its run.
	a_status_closes_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status != jsu_pkg::ST_DATA |-> out_item.last_of_run)
		else $error("status item not marked last of run");

	// Only error items carry an error code, and status items carry a zero byte.
	a_err_code_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((out_item.status == jsu_pkg::ST_ERROR) ==
			(out_item.error_code != jsu_pkg::ERR_NONE)))
		else $error("error code does not match status");

	a_status_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status != jsu_pkg::ST_DATA |-> out_item.out_byte == 8'd0)
		else $error("status item carries a nonzero byte");

	// A run is delivered without gaps once its first result is taken.
	a_run_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_item.last_of_run |=> out_valid)
		else $error("gap inside a run");

	// The output stage only becomes valid from a queued run.
	a_load_from_queue: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!q_stat.empty))
		else $error("output valid without a queued run");

	// Input is refused only when the queue is full.
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |=> $past(q_stat.full))
		else $error("input stalled with room in the queue");

endmodule

// ----- bench/tb_json_string_unescape_core.sv -----
// Self-checking bench for the JSON string unescaper: directed table, random strings, stalls.
module tb_json_string_unescape_core;

	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_HOLD   = 60;
	localparam int DRAIN_LIMIT = 2000;
	localparam int BYTE_TARGET = 430;

	// The eight characters that may follow a backslash as a single-character escape.
	localparam logic [7:0] ESC_LIST [8] = '{jsu_pkg::CH_BSLASH, jsu_pkg::CH_QUOTE,
		jsu_pkg::CH_SLASH, jsu_pkg::CH_B, jsu_pkg::CH_F, jsu_pkg::CH_N, jsu_pkg::CH_R,
		jsu_pkg::CH_T};

	// How the bench builds the expectation of one accepted item.
	typedef enum logic [1:0] {
		CHK_PREDICT,
		CHK_NONE,
		CHK_ONE
	} chk_mode_t;

	typedef struct packed {
		jsu_pkg::in_item_t  item;
		chk_mode_t          mode;
		jsu_pkg::out_item_t want;
	} smoke_row_t;

	// Decoder phases of the bench's own model of the block.
	typedef enum logic [6:0] {
		PH_IDLE     = 7'b0000001,
		PH_BODY     = 7'b0000010,
		PH_ESC      = 7'b0000100,
		PH_HEX1     = 7'b0001000,
		PH_HIGH     = 7'b0010000,
		PH_HIGH_ESC = 7'b0100000,
		PH_HEX2     = 7'b1000000
	} dec_phase_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	jsu_pkg::in_item_t  in_item;
	logic               out_valid;
	logic               out_ready;
	jsu_pkg::out_item_t out_item;

	chk_mode_t          row_mode;
	jsu_pkg::out_item_t row_want;
	smoke_row_t         smoke [29];
	jsu_pkg::in_item_t  text_q [$];
	jsu_pkg::out_item_t decoded_q [$];
	jsu_pkg::out_item_t byte_results [$];
	int                 counted_items = 0;
	int                 fail_cnt = 0;
	logic [31:0]        cycle_cnt = '0;
	logic               long_hold_done = 1'b0;

	// Decoder state as the bench sees it.
	dec_phase_t  dec_phase = PH_IDLE;
	logic [15:0] hex_acc = '0;
	logic [9:0]  high_bits = '0;
	logic [1:0]  digit_cnt = '0;
	logic [1:0]  cont_left = '0;
	logic        esc_seen = 1'b0;
	logic        raw_c0 = 1'b0;

	// Idling is switched off while cycle_cnt[8:7] is 2'b11 (a quarter of the time) and for the tail of the run.
	wire calm       = (cycle_cnt[8:7] == 2'b11);
	wire quiet_tail = (counted_items >= BYTE_TARGET - 50);

	always #5 clk = ~clk;

	json_string_unescape_core u_dut (
		.clk,
		.arst_n,
		.in_valid,
		.in_ready,
		.in_item,
		.out_valid,
		.out_ready,
		.out_item
	);

	// ---------------------------------------------------------------------------------
	// Unescape model: one input byte in, zero to four expected result items out.
	// ---------------------------------------------------------------------------------

	function automatic int utf8_len(input logic [7:0] c);
		casez (c)
			8'b0???????: return 1;
			8'b110?????: return 2;
			8'b1110????: return 3;
			8'b11110???: return 4;
			default:     return 0;
		endcase
	endfunction

	function automatic int nibble_of(input logic [7:0] c);
		if (c >= jsu_pkg::CH_0 && c <= jsu_pkg::CH_9)
			return int'(c) - int'(jsu_pkg::CH_0);
		if (c >= jsu_pkg::CH_LA && c <= jsu_pkg::CH_LF)
			return int'(c) - int'(jsu_pkg::CH_LA) + 10;
		if (c >= jsu_pkg::CH_UA && c <= jsu_pkg::CH_UF)
			return int'(c) - int'(jsu_pkg::CH_UA) + 10;
		return -1;
	endfunction

	// A byte caused by one input beyond the fourth is dropped, as the block has four slots.
	function void emit(input logic [7:0] b, input jsu_pkg::status_t st,
		input jsu_pkg::err_t e);
		jsu_pkg::out_item_t r;
		r.out_byte    = b;
		r.status      = st;
		r.error_code  = e;
		r.last_of_run = 1'b0;
		if (byte_results.size() < 4)
			byte_results.push_back(r);
	endfunction

	function void put_data(input logic [7:0] b);
		emit(b, jsu_pkg::ST_DATA, jsu_pkg::ERR_NONE);
	endfunction

	function void abort_string(input jsu_pkg::err_t e);
		emit(8'h00, jsu_pkg::ST_ERROR, e);
		dec_phase = PH_IDLE;
		cont_left = '0;
		raw_c0    = 1'b0;
	endfunction

	function void put_three(input logic [15:0] u);
		put_data({4'he, u[15:12]});
		put_data({2'b10, u[11:6]});
		put_data({2'b10, u[5:0]});
	endfunction

	function void clear_decoder();
		dec_phase = PH_IDLE;
		hex_acc   = '0;
		high_bits = '0;
		digit_cnt = '0;
		cont_left = '0;
		esc_seen  = 1'b0;
		raw_c0    = 1'b0;
	endfunction

	// A byte in the string body that is not a continuation byte.
	function void raw_body(input logic [7:0] c);
		int n;
		n = utf8_len(c);
		if (c <= jsu_pkg::CTRL_MAX) begin
			abort_string(jsu_pkg::ERR_CONTROL);
			return;
		end
		if (c == jsu_pkg::CH_BSLASH) begin
			esc_seen  = 1'b1;
			dec_phase = PH_ESC;
			return;
		end
		if (c == jsu_pkg::CH_QUOTE) begin
			emit(8'h00, jsu_pkg::ST_END, jsu_pkg::ERR_NONE);
			dec_phase = PH_IDLE;
			return;
		end
		if (n == 0) begin
			abort_string(jsu_pkg::ERR_BAD_LEAD);
			return;
		end
		// Only a C0 seen before any escape arms the check on the byte after it.
		if (c == jsu_pkg::RAW_C0 && !esc_seen)
			raw_c0 = 1'b1;
		put_data(c);
		cont_left = 2'(n - 1);
		dec_phase = PH_BODY;
	endfunction

	function void short_escape(input logic [7:0] c);
		logic [7:0] o;
		case (c)
			jsu_pkg::CH_BSLASH, jsu_pkg::CH_QUOTE, jsu_pkg::CH_SLASH: o = c;
			jsu_pkg::CH_B: o = 8'h08;
			jsu_pkg::CH_F: o = 8'h0c;
			jsu_pkg::CH_N: o = 8'h0a;
			jsu_pkg::CH_R: o = 8'h0d;
			jsu_pkg::CH_T: o = 8'h09;
			default: begin
				abort_string(jsu_pkg::ERR_BAD_ESCAPE);
				return;
			end
		endcase
		put_data(o);
		dec_phase = PH_BODY;
	endfunction

	// A completed first \u unit. A high surrogate is held until the next byte shows
	// whether a second unit follows.
	function void code_unit(input logic [15:0] u);
		dec_phase = PH_BODY;
		if (u <= 16'h007f) begin
			if (u == 16'h0000) begin
				put_data(8'hc0);
				put_data(8'h80);
			end else begin
				put_data(u[7:0]);
			end
		end else if (u <= 16'h07ff) begin
			put_data({3'b110, u[10:6]});
			put_data({2'b10, u[5:0]});
		end else if (u[15:10] == jsu_pkg::SURR_HIGH) begin
			high_bits = u[9:0];
			dec_phase = PH_HIGH;
		end else begin
			put_three(u);
		end
	endfunction

	function void unescape_byte(input logic [7:0] c, input logic sos);
		int                 d;
		logic [20:0]        cp;
		jsu_pkg::out_item_t tail;
		byte_results.delete();
		if (sos) begin
			// A start mark drops whatever string was in flight, silently.
			clear_decoder();
			if (c == jsu_pkg::CH_QUOTE)
				dec_phase = PH_BODY;
			else
				abort_string(jsu_pkg::ERR_NO_QUOTE);
		end else begin
			case (dec_phase)
				PH_BODY: begin
					if (cont_left != 2'd0) begin
						if (raw_c0 && c == jsu_pkg::CONT_80) begin
							abort_string(jsu_pkg::ERR_RAW_C0_80);
						end else begin
							raw_c0 = 1'b0;
							put_data(c);
							cont_left = cont_left - 2'd1;
						end
					end else begin
						raw_c0 = 1'b0;
						raw_body(c);
					end
				end
				PH_ESC: begin
					if (c == jsu_pkg::CH_U) begin
						dec_phase = PH_HEX1;
						hex_acc   = '0;
						digit_cnt = '0;
					end else begin
						short_escape(c);
					end
				end
				PH_HEX1, PH_HEX2: begin
					d = nibble_of(c);
					if (d < 0) begin
						// A held high surrogate still goes out before the error.
						if (dec_phase == PH_HEX2)
							put_three({jsu_pkg::SURR_HIGH, high_bits});
						abort_string(jsu_pkg::ERR_BAD_ESCAPE);
					end else begin
						hex_acc = {hex_acc[11:0], 4'(d)};
						if (digit_cnt == 2'd3) begin
							digit_cnt = '0;
							if (dec_phase == PH_HEX1) begin
								code_unit(hex_acc);
							end else begin
								// The second unit is combined without checking it is a low
								// surrogate.
								cp = {1'b0, high_bits, hex_acc[9:0]} + jsu_pkg::SUPP_BASE;
								put_data({5'b11110, cp[20:18]});
								put_data({2'b10, cp[17:12]});
								put_data({2'b10, cp[11:6]});
								put_data({2'b10, cp[5:0]});
								dec_phase = PH_BODY;
							end
						end else begin
							digit_cnt = digit_cnt + 2'd1;
						end
					end
				end
				PH_HIGH: begin
					if (c == jsu_pkg::CH_BSLASH) begin
						dec_phase = PH_HIGH_ESC;
					end else begin
						put_three({jsu_pkg::SURR_HIGH, high_bits});
						dec_phase = PH_BODY;
						raw_body(c);
					end
				end
				PH_HIGH_ESC: begin
					if (c == jsu_pkg::CH_U) begin
						dec_phase = PH_HEX2;
						hex_acc   = '0;
						digit_cnt = '0;
					end else begin
						put_three({jsu_pkg::SURR_HIGH, high_bits});
						short_escape(c);
					end
				end
				default: ;
			endcase
		end
		if (byte_results.size() != 0) begin
			tail = byte_results.pop_back();
			tail.last_of_run = 1'b1;
			byte_results.push_back(tail);
		end
	endfunction

	// ---------------------------------------------------------------------------------
	// Checking and prediction, both at the rising edge. Results of an item pass through
	// the run queue and the output register before they can come out, so the order of the
	// two parts here does not matter.
	// ---------------------------------------------------------------------------------

	always @(posedge clk) begin
		jsu_pkg::out_item_t want;
		if (out_valid && out_ready) begin
			if (decoded_q.size() == 0) begin
				$error("out_item: no result expected, got byte %h status %0d error %0d",
					out_item.out_byte, out_item.status, out_item.error_code);
				fail_cnt++;
			end else begin
				want = decoded_q.pop_front();
				if (out_item.out_byte !== want.out_byte) begin
					$error("out_byte: expected %h, got %h", want.out_byte, out_item.out_byte);
					fail_cnt++;
				end
				if (out_item.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, out_item.status);
					fail_cnt++;
				end
				if (out_item.error_code !== want.error_code) begin
					$error("error_code: expected %0d, got %0d", want.error_code,
						out_item.error_code);
					fail_cnt++;
				end
				if (out_item.last_of_run !== want.last_of_run) begin
					$error("last_of_run: expected %0d, got %0d", want.last_of_run,
						out_item.last_of_run);
					fail_cnt++;
				end
			end
		end
		if (in_valid && in_ready) begin
			// Bytes that arrive while idle without a start mark do nothing and are not counted.
			if (dec_phase != PH_IDLE || in_item.start_of_string)
				counted_items++;
			unescape_byte(in_item.in_byte, in_item.start_of_string);
			case (row_mode)
				CHK_PREDICT: foreach (byte_results[j]) decoded_q.push_back(byte_results[j]);
				CHK_ONE:     decoded_q.push_back(row_want);
				default:     ;
			endcase
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 32'd1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// ---------------------------------------------------------------------------------
	// Receiver: random stall bursts, plus one long hold-off that fills the run queue
	// and pushes back on the input while the sender keeps offering.
	// ---------------------------------------------------------------------------------

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!long_hold_done && counted_items >= 150) begin
				long_hold_done = 1'b1;
				out_ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
			end else if (!quiet_tail && !calm && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(0, 4)) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------------------------
	// Sender
	// ---------------------------------------------------------------------------------

	function automatic smoke_row_t mk(input logic [7:0] b, input logic sos,
		input chk_mode_t m, input logic [7:0] ob = 8'h00,
		input jsu_pkg::status_t st = jsu_pkg::ST_DATA,
		input jsu_pkg::err_t e = jsu_pkg::ERR_NONE);
		smoke_row_t r;
		r.item.in_byte          = b;
		r.item.start_of_string  = sos;
		r.mode                  = m;
		r.want.out_byte         = ob;
		r.want.status           = st;
		r.want.error_code       = e;
		r.want.last_of_run      = 1'b1;
		return r;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10)
			return jsu_pkg::CH_0 + 8'(n);
		// Mixed case, since both are legal hex digits.
		return ($urandom_range(0, 1) != 0 ? jsu_pkg::CH_LA : jsu_pkg::CH_UA) + 8'(n) - 8'd10;
	endfunction

	function automatic logic [7:0] non_hex_char();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (nibble_of(b) >= 0);
		return b;
	endfunction

	task automatic push_txt(input logic [7:0] b);
		jsu_pkg::in_item_t it;
		it.in_byte         = b;
		it.start_of_string = 1'b0;
		text_q.push_back(it);
	endtask

	task automatic push_printable();
		logic [7:0] b;
		b = 8'($urandom_range(32, 127));
		if (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BSLASH)
			b = jsu_pkg::CH_UA;
		push_txt(b);
	endtask

	task automatic push_unit(input logic [15:0] u);
		push_txt(jsu_pkg::CH_BSLASH);
		push_txt(jsu_pkg::CH_U);
		for (int i = 3; i >= 0; i--)
			push_txt(hex_char(u[i * 4 +: 4]));
	endtask

	// A \u escape cut short by a non-hex character after zero to three digits.
	task automatic push_broken_unit();
		push_txt(jsu_pkg::CH_BSLASH);
		push_txt(jsu_pkg::CH_U);
		repeat ($urandom_range(0, 3)) push_txt(hex_char(4'($urandom_range(0, 15))));
		push_txt(non_hex_char());
	endtask

	// One quoted string: mostly well formed with random content, with noise, bad escapes,
	// truncation and missing quotes mixed in.
	task automatic build_string();
		jsu_pkg::in_item_t it;
		logic [15:0]       u;
		logic [7:0]        b;
		int                n;
		if ($urandom_range(0, 7) == 0)
			repeat ($urandom_range(1, 3)) push_txt(8'($urandom_range(0, 255)));
		it.start_of_string = 1'b1;
		it.in_byte = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
			: jsu_pkg::CH_QUOTE;
		text_q.push_back(it);
		repeat ($urandom_range(0, 6)) begin
			case ($urandom_range(0, 15))
				0, 1, 2, 3: push_printable();
				4, 5: begin
					push_txt(jsu_pkg::CH_BSLASH);
					push_txt(ESC_LIST[3'($urandom_range(0, 7))]);
				end
				6, 7: begin
					case ($urandom_range(0, 4))
						0:       u = 16'h0000;
						1:       u = 16'($urandom_range(1, 16'h007f));
						2:       u = 16'($urandom_range(16'h0080, 16'h07ff));
						3:       u = 16'($urandom_range(16'h0800, 16'hffff));
						default: u = ($urandom_range(0, 1) != 0) ? 16'h07ff : 16'hffff;
					endcase
					push_unit(u);
				end
				8: begin
					push_unit({jsu_pkg::SURR_HIGH, 10'($urandom_range(0, 1023))});
					if ($urandom_range(0, 7) == 0)
						push_unit(16'($urandom_range(0, 16'hffff)));
					else
						push_unit({6'b110111, 10'($urandom_range(0, 1023))});
				end
				9: begin
					// High surrogate with no second unit after it.
					push_unit({jsu_pkg::SURR_HIGH, 10'($urandom_range(0, 1023))});
					case ($urandom_range(0, 3))
						0: push_printable();
						1: begin
							push_txt(jsu_pkg::CH_BSLASH);
							push_txt(ESC_LIST[3'($urandom_range(0, 7))]);
						end
						2: push_broken_unit();
						default: ;
					endcase
				end
				10, 11: begin
					n = $urandom_range(2, 4);
					case (n)
						2:       push_txt({3'b110, 5'($urandom_range(0, 31))});
						3:       push_txt({4'b1110, 4'($urandom_range(0, 15))});
						default: push_txt({5'b11110, 3'($urandom_range(0, 7))});
					endcase
					// Continuation bytes are not checked, so some are arbitrary.
					repeat (n - 1) begin
						if ($urandom_range(0, 7) == 0)
							push_txt(8'($urandom_range(0, 255)));
						else
							push_txt({2'b10, 6'($urandom_range(0, 63))});
					end
				end
				12: begin
					push_txt(jsu_pkg::RAW_C0);
					push_txt(($urandom_range(0, 1) != 0) ? jsu_pkg::CONT_80
						: {2'b10, 6'($urandom_range(0, 63))});
				end
				13: push_txt(8'($urandom_range(0, 255)));
				14: begin
					push_txt(jsu_pkg::CH_BSLASH);
					b = 8'($urandom_range(0, 255));
					push_txt(b);
				end
				default: push_broken_unit();
			endcase
		end
		// Some strings are left open; the next start mark then drops them.
		if ($urandom_range(0, 9) != 0)
			push_txt(jsu_pkg::CH_QUOTE);
	endtask

	// Called at a falling edge; returns at the falling edge after the item is taken.
	task automatic offer(input jsu_pkg::in_item_t it, input chk_mode_t m,
		input jsu_pkg::out_item_t w);
		in_item  <= it;
		row_mode <= m;
		row_want <= w;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	task automatic sender_gap();
		if (!quiet_tail && !calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
	endtask

	initial begin
		int k;
		bit paused;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		in_item  = '0;
		row_mode = CHK_PREDICT;
		row_want = '0;
		paused   = 1'b0;

		// Directed strings. Single-result rows carry their answer here; the rest go through
		// the model above.
		smoke = '{
			mk("A", 1'b0, CHK_NONE),                                   // idle, ignored
			mk("A", 1'b1, CHK_ONE, 8'h00, jsu_pkg::ST_ERROR, jsu_pkg::ERR_NO_QUOTE),
			mk(jsu_pkg::CH_QUOTE, 1'b1, CHK_NONE),
			mk(jsu_pkg::RAW_C0, 1'b0, CHK_ONE, jsu_pkg::RAW_C0),
			mk(jsu_pkg::CONT_80, 1'b0, CHK_ONE, 8'h00, jsu_pkg::ST_ERROR,
				jsu_pkg::ERR_RAW_C0_80),
			mk(jsu_pkg::CH_QUOTE, 1'b1, CHK_NONE),
			mk(8'hff, 1'b0, CHK_ONE, 8'h00, jsu_pkg::ST_ERROR, jsu_pkg::ERR_BAD_LEAD),
			mk(jsu_pkg::CH_QUOTE, 1'b1, CHK_NONE),
			mk(8'h00, 1'b0, CHK_ONE, 8'h00, jsu_pkg::ST_ERROR, jsu_pkg::ERR_CONTROL),
			mk(jsu_pkg::CH_QUOTE, 1'b1, CHK_NONE),
			mk(jsu_pkg::CH_BSLASH, 1'b0, CHK_NONE),
			mk("x", 1'b0, CHK_ONE, 8'h00, jsu_pkg::ST_ERROR, jsu_pkg::ERR_BAD_ESCAPE),
			mk(jsu_pkg::CH_QUOTE, 1'b1, CHK_NONE),
			// U+0000 comes out as the two-byte form.
			mk(jsu_pkg::CH_BSLASH, 1'b0, CHK_NONE),
			mk(jsu_pkg::CH_U, 1'b0, CHK_NONE),
			mk("0", 1'b0, CHK_NONE),
			mk("0", 1'b0, CHK_NONE),
			mk("0", 1'b0, CHK_NONE),
			mk("0", 1'b0, CHK_PREDICT),
			// High surrogate followed by a plain byte: three bytes plus the plain one.
			mk(jsu_pkg::CH_BSLASH, 1'b0, CHK_NONE),
			mk(jsu_pkg::CH_U, 1'b0, CHK_NONE),
			mk("d", 1'b0, CHK_NONE),
			mk("8", 1'b0, CHK_NONE),
			mk("0", 1'b0, CHK_NONE),
			mk("0", 1'b0, CHK_NONE),
			mk("A", 1'b0, CHK_PREDICT),
			// A start mark in the middle of an escape drops it without a result.
			mk(jsu_pkg::CH_BSLASH, 1'b0, CHK_NONE),
			mk(jsu_pkg::CH_QUOTE, 1'b1, CHK_NONE),
			mk(jsu_pkg::CH_QUOTE, 1'b0, CHK_ONE, 8'h00, jsu_pkg::ST_END, jsu_pkg::ERR_NONE)
		};

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (smoke[i]) begin
			offer(smoke[i].item, smoke[i].mode, smoke[i].want);
			sender_gap();
		end

		while (counted_items < BYTE_TARGET) begin
			// Once, let the output side drain completely before going on.
			if (!paused && counted_items >= 300) begin
				paused = 1'b1;
				in_valid <= 1'b0;
				do
					@(negedge clk);
				while (decoded_q.size() != 0);
			end
			build_string();
			while (text_q.size() != 0) begin
				offer(text_q.pop_front(), CHK_PREDICT, '0);
				sender_gap();
			end
		end

		in_valid <= 1'b0;
		for (k = 0; k < DRAIN_LIMIT && decoded_q.size() != 0; k++)
			@(negedge clk);
		// Results that no item should cause may still come out; give them time to misbehave.
		repeat (20) @(negedge clk);
		if (decoded_q.size() != 0) begin
			$error("%0d expected results never arrived", decoded_q.size());
			fail_cnt++;
		end
		if (fail_cnt == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
